// ===== src/pvp_pkg.sv =====
// pvp_pkg: shared types and constants for the perspective vertex projection
// depends on nothing
`timescale 1ns / 1ps
package pvp_pkg;

  localparam int CoordBits = 32;
  localparam int FracBits = 16;
  localparam int FocalBits = 31;
  localparam int WinBits = 13;
  localparam int ViewBits = CoordBits + 1;
  localparam int MagBits = CoordBits + 1;
  localparam int ProdBits = MagBits + FocalBits;
  localparam int QuotBits = ProdBits;
  localparam int SentinelInt = 6999;
  localparam int CfgIdxBits = 3;
  localparam int CfgDataBits = 32;

  typedef enum logic [CfgIdxBits-1:0] {
    REG_CAMERA_X = 3'd0,
    REG_CAMERA_Y = 3'd1,
    REG_CAMERA_Z = 3'd2,
    REG_FOCAL    = 3'd3,
    REG_WIN_W    = 3'd4,
    REG_WIN_H    = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic signed [CoordBits-1:0] vertex_x;
    logic signed [CoordBits-1:0] vertex_y;
    logic signed [CoordBits-1:0] vertex_z;
  } vertex_t;

  typedef struct packed {
    logic signed [CoordBits-1:0] pixel_x;
    logic signed [CoordBits-1:0] pixel_y;
    logic                        behind_camera;
  } pixel_t;

  // classified item passed from front to back
  typedef struct packed {
    logic                behind;
    logic                neg_x;
    logic                neg_y;
    logic [MagBits-1:0]  mag_x;
    logic [MagBits-1:0]  mag_y;
    logic [MagBits-1:0]  depth;
  } job_t;

  localparam int JobBits = $bits(job_t);

endpackage

// ===== src/pvp_fifo.sv =====
// pvp_fifo: small first-word-fall-through queue with registered storage
// depends on nothing (widths are passed in as parameters)
`timescale 1ns / 1ps
module pvp_fifo #(
  parameter int Width = 8,
  parameter int Depth = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [Width-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [Width-1:0] rdata,
  output logic             empty
);
  localparam int AW = $clog2(Depth);
  logic [Width-1:0] mem [Depth];
  logic [AW-1:0] wp, rp;
  logic [AW:0] cnt;
  logic do_push, do_pop;

  assign full = (cnt == (AW+1)'(Depth));
  assign empty = (cnt == '0);
  assign do_push = push && !full;
  assign do_pop = pop && !empty;
  assign rdata = mem[rp];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wp] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      cnt <= '0;
    end else begin
      if (do_push) begin
        wp <= (wp == AW'(Depth-1)) ? '0 : wp + 1'b1;
      end
      if (do_pop) begin
        rp <= (rp == AW'(Depth-1)) ? '0 : rp + 1'b1;
      end
      cnt <= cnt + (AW+1)'(do_push) - (AW+1)'(do_pop);
    end
  end
endmodule

// ===== src/pvp_front.sv =====
// pvp_front: subtracts camera position and classifies vertex as behind or in view
// depends on pvp_pkg
`timescale 1ns / 1ps
module pvp_front import pvp_pkg::*; (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  vertex_t                     in_data,
  output logic                        in_ready,
  input  logic signed [CoordBits-1:0] cam_x,
  input  logic signed [CoordBits-1:0] cam_y,
  input  logic signed [CoordBits-1:0] cam_z,
  output logic                        job_valid,
  output job_t                        job,
  input  logic                        job_ready
);
  logic signed [ViewBits-1:0] vx, vy, vz;
  job_t job_next;

  assign in_ready = !job_valid || job_ready;

  always_comb begin
    vx = ViewBits'(in_data.vertex_x) - ViewBits'(cam_x);
    vy = ViewBits'(in_data.vertex_y) - ViewBits'(cam_y);
    vz = ViewBits'(in_data.vertex_z) - ViewBits'(cam_z);
    job_next.behind = (vz <= 0);
    job_next.neg_x = vx[ViewBits-1];
    job_next.neg_y = vy[ViewBits-1];
    job_next.mag_x = vx[ViewBits-1] ? MagBits'(-vx) : MagBits'(vx);
    job_next.mag_y = vy[ViewBits-1] ? MagBits'(-vy) : MagBits'(vy);
    job_next.depth = MagBits'(vz);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
    end else if (in_ready) begin
      job_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      job <= job_next;
    end
  end
endmodule

// ===== src/pvp_back.sv =====
// pvp_back: multiplies by focal length, pipelined restoring divide, offset and saturate
// depends on pvp_pkg
`timescale 1ns / 1ps
module pvp_back import pvp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 job_valid,
  input  job_t                 job,
  output logic                 job_ready,
  input  logic [FocalBits-1:0] focal,
  input  logic [WinBits-1:0]   win_w,
  input  logic [WinBits-1:0]   win_h,
  output logic                 res_valid,
  output pixel_t               res,
  input  logic                 res_ready
);
  localparam int Steps = ProdBits;
  localparam int RemBits = MagBits + 1;
  localparam int SumBits = CoordBits + 3;

  typedef struct packed {
    logic                behind;
    logic                neg_x;
    logic                neg_y;
    logic [MagBits-1:0]  depth;
    logic [ProdBits-1:0] nx;
    logic [ProdBits-1:0] ny;
    logic [RemBits-1:0]  rx;
    logic [RemBits-1:0]  ry;
  } div_t;

  logic adv;
  logic [Steps:0] v;
  div_t st [Steps+1];
  div_t nxt [Steps];
  div_t sreg [Steps];
  logic [ProdBits-1:0] px, py;
  logic [MagBits-1:0] depth0;
  logic b0, nx0, ny0;

  assign adv = !res_valid || res_ready;
  assign job_ready = adv;

  // multiply stage (33 x 31)
  always_ff @(posedge clk) begin
    if (adv) begin
      px <= ProdBits'(job.mag_x) * ProdBits'(focal);
      py <= ProdBits'(job.mag_y) * ProdBits'(focal);
      depth0 <= job.depth;
      b0 <= job.behind;
      nx0 <= job.neg_x;
      ny0 <= job.neg_y;
    end
  end

  always_comb begin
    st[0].behind = b0;
    st[0].neg_x = nx0;
    st[0].neg_y = ny0;
    st[0].depth = depth0;
    st[0].nx = px;
    st[0].ny = py;
    st[0].rx = '0;
    st[0].ry = '0;
    for (int i = 1; i <= Steps; i++) begin
      st[i] = sreg[i-1];
    end
  end

  // one quotient bit per stage, quotient shifts into numerator register
  always_comb begin
    logic [RemBits-1:0] tx, ty;
    for (int i = 0; i < Steps; i++) begin
      nxt[i] = st[i];
      tx = {st[i].rx[RemBits-2:0], st[i].nx[ProdBits-1]};
      ty = {st[i].ry[RemBits-2:0], st[i].ny[ProdBits-1]};
      nxt[i].nx = {st[i].nx[ProdBits-2:0], 1'b0};
      nxt[i].ny = {st[i].ny[ProdBits-2:0], 1'b0};
      if (tx >= RemBits'(st[i].depth)) begin
        tx = tx - RemBits'(st[i].depth);
        nxt[i].nx[0] = 1'b1;
      end
      if (ty >= RemBits'(st[i].depth)) begin
        ty = ty - RemBits'(st[i].depth);
        nxt[i].ny[0] = 1'b1;
      end
      nxt[i].rx = tx;
      nxt[i].ry = ty;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < Steps; i++) begin
        sreg[i] <= nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (adv) begin
      v <= {v[Steps-1:0], job_valid};
    end
  end

  function automatic logic signed [CoordBits-1:0] sat(input logic signed [SumBits-1:0] s);
    logic signed [SumBits-1:0] hi, lo;
    begin
      hi = SumBits'({1'b0, {(CoordBits-1){1'b1}}});
      lo = -hi - SumBits'(1);
      if (s > hi) sat = CoordBits'(hi);
      else if (s < lo) sat = CoordBits'(lo);
      else sat = CoordBits'(s);
    end
  endfunction

  logic [ProdBits-1:0] qx, qy;
  logic signed [SumBits-1:0] sx, sy, hw, hh;
  pixel_t out_next;

  always_comb begin
    qx = st[Steps].nx;
    qy = st[Steps].ny;
    // quotient above the coordinate range saturates either way
    sx = (qx >= ProdBits'(1) << (CoordBits + 1)) ? SumBits'(1) << (CoordBits + 1)
                                                  : SumBits'(qx);
    sy = (qy >= ProdBits'(1) << (CoordBits + 1)) ? SumBits'(1) << (CoordBits + 1)
                                                  : SumBits'(qy);
    if (st[Steps].neg_x) sx = -sx;
    if (st[Steps].neg_y) sy = -sy;
    hw = SumBits'(win_w) << (FracBits - 1);
    hh = SumBits'(win_h) << (FracBits - 1);
    if (st[Steps].behind) begin
      out_next.pixel_x = -CoordBits'(SentinelInt << FracBits);
      out_next.pixel_y = -CoordBits'(SentinelInt << FracBits);
      out_next.behind_camera = 1'b1;
    end else begin
      out_next.pixel_x = sat(sx + hw);
      out_next.pixel_y = sat(hh - sy);
      out_next.behind_camera = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (adv) begin
      res_valid <= v[Steps];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res <= out_next;
    end
  end
endmodule

// ===== src/perspective_vertex_projection.sv =====
// perspective_vertex_projection: top level, config registers, front, queue, back
// depends on pvp_pkg, pvp_front, pvp_fifo, pvp_back
//
// channel   direction  handshake        payload
// vertex    in         push / full      vertex (vertex_t)
// pixel     out        pop / empty      pixel (pixel_t)
// config    in         cfg_we           cfg_idx, cfg_data
//
// one vertex per cycle while neither queue nor pixel output stalls; a vertex
// passes front, queue, multiply, 64-stage divider and output registers
// rst synchronous, clears all valid bits and loads register reset values
// a stalled pixel output freezes the back pipeline; the queue absorbs the front
`timescale 1ns / 1ps
module perspective_vertex_projection import pvp_pkg::*; #(
  parameter int QueueDepth = 4
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  output logic                   full,
  input  vertex_t                vertex,
  input  logic                   pop,
  output logic                   empty,
  output pixel_t                 pixel,
  input  logic                   cfg_we,
  input  logic [CfgIdxBits-1:0]  cfg_idx,
  input  logic [CfgDataBits-1:0] cfg_data
);
  logic signed [CoordBits-1:0] cam_x, cam_y, cam_z;
  logic [FocalBits-1:0] focal;
  logic [WinBits-1:0] win_w, win_h;

  always_ff @(posedge clk) begin
    if (rst) begin
      cam_x <= '0;
      cam_y <= '0;
      cam_z <= '0;
      focal <= FocalBits'(1) << FracBits;
      win_w <= WinBits'(640);
      win_h <= WinBits'(480);
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_CAMERA_X: cam_x <= cfg_data;
        REG_CAMERA_Y: cam_y <= cfg_data;
        REG_CAMERA_Z: cam_z <= cfg_data;
        REG_FOCAL:    focal <= cfg_data[FocalBits-1:0];
        REG_WIN_W:    win_w <= cfg_data[WinBits-1:0];
        REG_WIN_H:    win_h <= cfg_data[WinBits-1:0];
        default: ;
      endcase
    end
  end

  logic in_ready, f_valid, f_ready, q_full, q_empty, b_ready, res_valid;
  job_t f_job, q_job;

  assign full = !in_ready;

  pvp_front u_front (
    .clk, .rst,
    .in_valid(push), .in_data(vertex), .in_ready,
    .cam_x, .cam_y, .cam_z,
    .job_valid(f_valid), .job(f_job), .job_ready(f_ready)
  );

  assign f_ready = !q_full;

  pvp_fifo #(.Width(JobBits), .Depth(QueueDepth)) u_queue (
    .clk, .rst,
    .push(f_valid), .wdata(f_job), .full(q_full),
    .pop(b_ready), .rdata(q_job), .empty(q_empty)
  );

  pvp_back u_back (
    .clk, .rst,
    .job_valid(!q_empty), .job(q_job), .job_ready(b_ready),
    .focal, .win_w, .win_h,
    .res_valid, .res(pixel), .res_ready(pop)
  );

  assign empty = !res_valid;

`ifndef SYNTHESIS
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(pixel)))
    else $error("pixel changed while stalled");
  a_behind_sentinel: assert property (@(posedge clk) disable iff (rst)
    (!empty && pixel.behind_camera) |->
      (pixel.pixel_x == pixel.pixel_y && pixel.pixel_x[CoordBits-1]))
    else $error("behind result without sentinel");
  a_full_ok: assert property (@(posedge clk) disable iff (rst)
    full |-> f_valid)
    else $error("full without pending front item");
`endif
endmodule

// ===== tb/tb_top.sv =====
// tb_top: randomized and directed testbench for perspective_vertex_projection
// depends on pvp_pkg and the perspective_vertex_projection rtl
// a scoreboard class predicts each pixel request from the accepted vertex
`timescale 1ns / 1ps
module tb_top;
  import pvp_pkg::*;

  localparam int LatencyCycles = 100;
  localparam longint CycleLimit = 1000000;

  class projection_scoreboard;
    longint cam_x, cam_y, cam_z;
    longint unsigned focal, win_w, win_h;
    pixel_t pending[$];
    int errors;
    int mismatches;

    function void reset_regs();
      cam_x = 0; cam_y = 0; cam_z = 0;
      focal = 65536; win_w = 640; win_h = 480;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [31:0] val);
      case (idx)
        REG_CAMERA_X: cam_x = longint'($signed(val));
        REG_CAMERA_Y: cam_y = longint'($signed(val));
        REG_CAMERA_Z: cam_z = longint'($signed(val));
        REG_FOCAL: focal = 64'(val[30:0]);
        REG_WIN_W: win_w = 64'(val[12:0]);
        REG_WIN_H: win_h = 64'(val[12:0]);
        default: ;
      endcase
    endfunction

    function longint clamp_coord(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function longint scale_by_depth(longint view, longint depth);
      logic [127:0] prod, quot;
      logic [63:0] mag;
      longint q;
      mag = (view < 0) ? -view : view;
      prod = 128'(mag) * 128'(focal);
      quot = prod / 128'(depth);
      if (quot > (128'd1 << 62)) q = longint'(64'd1 << 62);
      else q = longint'(quot[63:0]);
      return (view < 0) ? -q : q;
    endfunction

    function void note_vertex(vertex_t v);
      pixel_t p;
      longint vx, vy, vz, sx, sy;
      vx = longint'(v.vertex_x) - cam_x;
      vy = longint'(v.vertex_y) - cam_y;
      vz = longint'(v.vertex_z) - cam_z;
      if (vz <= 0) begin
        p.pixel_x = -32'sd6999 <<< FracBits;
        p.pixel_y = -32'sd6999 <<< FracBits;
        p.behind_camera = 1'b1;
      end else begin
        sx = scale_by_depth(vx, vz);
        sy = scale_by_depth(vy, vz);
        p.pixel_x = 32'(clamp_coord(sx + longint'(win_w << (FracBits - 1))));
        p.pixel_y = 32'(clamp_coord(longint'(win_h << (FracBits - 1)) - sy));
        p.behind_camera = 1'b0;
      end
      pending.push_back(p);
    endfunction

    function void check_pixel(pixel_t got);
      pixel_t want;
      if (pending.size() == 0) begin
        errors++;
        if (mismatches++ < 10) $display("unexpected pixel %h", got);
        return;
      end
      want = pending.pop_front();
      if (got.pixel_x !== want.pixel_x || got.pixel_y !== want.pixel_y ||
          got.behind_camera !== want.behind_camera) begin
        errors++;
        if (mismatches++ < 10)
          $display("mismatch exp x=%h y=%h b=%b got x=%h y=%h b=%b",
                   want.pixel_x, want.pixel_y, want.behind_camera,
                   got.pixel_x, got.pixel_y, got.behind_camera);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  vertex_t vertex = '0;
  logic pop = 1'b0;
  logic empty;
  pixel_t pixel;
  logic cfg_we = 1'b0;
  logic [CfgIdxBits-1:0] cfg_idx = '0;
  logic [CfgDataBits-1:0] cfg_data = '0;

  projection_scoreboard board;
  longint cycles = 0;
  int hold_off = 0;
  bit stall_on = 1'b0;

  perspective_vertex_projection i_dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .vertex(vertex),
    .pop(pop), .empty(empty), .pixel(pixel),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("perspective_vertex_projection test failed");
      $finish;
    end
  end

  // receiver: check accepted requests, stall on its own pattern
  always @(posedge clk) begin
    if (!rst) begin
      if (pop && !empty) board.check_pixel(pixel);
      if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        pop <= 1'b0;
      end else if (stall_on) begin
        pop <= ($urandom_range(0, 3) != 0);
      end else begin
        pop <= 1'b1;
      end
    end
  end

  task automatic write_cfg(cfg_reg_t idx, logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    board.write_reg(idx, val);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    while (board.pending.size() != 0) @(posedge clk);
    repeat (LatencyCycles) @(posedge clk);
  endtask

  // offer one vertex and hold it until accepted
  task automatic send_vertex(vertex_t v);
    push <= 1'b1;
    vertex <= v;
    @(posedge clk);
    while (full) @(posedge clk);
    board.note_vertex(v);
  endtask

  task automatic idle_gap(int n);
    push <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord(int mode);
    case (mode)
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 20'hfffff)) - 32'sh80000);
      2: return {$urandom_range(0, 1) ? 16'hffff : 16'h0000, 16'($urandom())};
      default: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
    endcase
  endfunction

  task automatic random_phase(int count);
    vertex_t v;
    int burst;
    int sent;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 40);
      repeat (burst) begin
        v.vertex_x = rand_coord($urandom_range(0, 3));
        v.vertex_y = rand_coord($urandom_range(0, 3));
        if ($urandom_range(0, 4) == 0) v.vertex_z = rand_coord($urandom_range(0, 3));
        else v.vertex_z = 32'(board.cam_z + longint'($urandom_range(1, 32'h7fffff)));
        send_vertex(v);
        sent++;
      end
      if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 12));
    end
    push <= 1'b0;
  endtask

  task automatic random_config();
    write_cfg(REG_CAMERA_X, $urandom_range(0, 1) ? $urandom() : 32'($urandom_range(0, 20'hfffff)));
    write_cfg(REG_CAMERA_Y, $urandom());
    write_cfg(REG_CAMERA_Z, 32'($signed($urandom_range(0, 24'hffffff)) - 32'sh800000));
    write_cfg(REG_FOCAL, $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 32'h7ffff));
    write_cfg(REG_WIN_W, $urandom_range(0, 8191));
    write_cfg(REG_WIN_H, $urandom_range(0, 8191));
  endtask

  initial begin
    vertex_t v;
    board = new();
    board.reset_regs();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    repeat (LatencyCycles) @(posedge clk);

    // directed: extremes, depth zero and negative, saturation
    v = '{32'h0001_0000, 32'h0001_0000, 32'h0001_0000}; send_vertex(v);
    v = '{32'h7fffffff, 32'h80000000, 32'h0000_0001}; send_vertex(v);
    v = '{32'h80000000, 32'h7fffffff, 32'h0000_0001}; send_vertex(v);
    v = '{32'h0, 32'h0, 32'h0}; send_vertex(v);
    v = '{32'hffffffff, 32'hffffffff, 32'hffffffff}; send_vertex(v);
    v = '{32'h1234_5678, 32'h8765_4321, 32'h80000000}; send_vertex(v);
    v = '{32'h7fffffff, 32'h7fffffff, 32'h7fffffff}; send_vertex(v);
    v = '{32'h80000000, 32'h80000000, 32'h7fffffff}; send_vertex(v);
    idle_gap(1);
    drain();

    write_cfg(REG_CAMERA_X, 32'h80000000);
    write_cfg(REG_CAMERA_Y, 32'h7fffffff);
    write_cfg(REG_CAMERA_Z, 32'h80000000);
    write_cfg(REG_FOCAL, 32'h7fffffff);
    write_cfg(REG_WIN_W, 32'd8191);
    write_cfg(REG_WIN_H, 32'd0);
    v = '{32'h7fffffff, 32'h80000000, 32'h7fffffff}; send_vertex(v);
    v = '{32'h0, 32'h0, 32'h80000000}; send_vertex(v);
    v = '{32'h80000000, 32'h7fffffff, 32'h80000001}; send_vertex(v);
    idle_gap(1);
    drain();
    write_cfg(REG_FOCAL, 32'h0);
    write_cfg(REG_WIN_W, 32'd1);
    write_cfg(REG_WIN_H, 32'd4096);
    v = '{32'h7fffffff, 32'h80000000, 32'h7fffffff}; send_vertex(v);
    v = '{32'h1, 32'hffffffff, 32'h0}; send_vertex(v);
    idle_gap(1);
    drain();

    // default camera, receiver held off so the queue fills and stalls input
    write_cfg(REG_CAMERA_X, 32'h0);
    write_cfg(REG_CAMERA_Y, 32'h0);
    write_cfg(REG_CAMERA_Z, 32'h0);
    write_cfg(REG_FOCAL, 32'h0001_0000);
    write_cfg(REG_WIN_W, 32'd640);
    write_cfg(REG_WIN_H, 32'd480);
    hold_off <= 300;
    random_phase(200);
    drain();

    stall_on <= 1'b1;
    repeat (4) begin
      random_config();
      random_phase(220);
      drain();
    end
    stall_on <= 1'b0;

    if (board.errors == 0 && board.pending.size() == 0)
      $display("perspective_vertex_projection test passed");
    else
      $display("perspective_vertex_projection test failed");
    $finish;
  end
endmodule
